// ----- rtl/core/fsjsc_pkg.sv -----
// Shared types, codes and reset values for the five-servo jog and slew controller.
// No dependencies; imported by the controller top level.
package fsjsc_pkg;

	localparam int NUM_SERVOS = 5;
	localparam int ANGLE_W    = 8;
	localparam int STEP_W     = 5;
	localparam int CMD_W      = 4;
	localparam int IDX_W      = 3;
	localparam int TGT_W      = 10;
	localparam int CLAMP_W    = 11;
	localparam int IDLE_W     = 8;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 8;

	typedef logic [ANGLE_W-1:0]    angle_t;
	typedef logic [STEP_W-1:0]     step_t;
	typedef logic [CMD_W-1:0]      cmd_t;
	typedef logic [NUM_SERVOS-1:0] servo_mask_t;

	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_JOG        = 2'd1,
		OP_SET_TARGET = 2'd2,
		OP_RAW        = 2'd3
	} opcode_t;

	localparam cmd_t CMD_STOP      = 4'd0;
	localparam cmd_t CMD_UP        = 4'd1;
	localparam cmd_t CMD_DOWN      = 4'd2;
	localparam cmd_t CMD_CLOSE     = 4'd3;
	localparam cmd_t CMD_OPEN      = 4'd4;
	localparam cmd_t CMD_WRIST_CCW = 4'd5;
	localparam cmd_t CMD_TILT_UP   = 4'd6;
	localparam cmd_t CMD_TILT_DOWN = 4'd7;
	localparam cmd_t CMD_WRIST_CW  = 4'd8;
	localparam cmd_t CMD_OTHER     = 4'd9;

	localparam int SERVO_CLAW  = 0;
	localparam int SERVO_WRIST = 1;
	localparam int SERVO_TILT  = 2;
	localparam int SERVO_ARM_A = 3;
	localparam int SERVO_ARM_B = 4;

	localparam servo_mask_t MASK_CLAW  = 5'b00001;
	localparam servo_mask_t MASK_WRIST = 5'b00010;
	localparam servo_mask_t MASK_TILT  = 5'b00100;
	localparam servo_mask_t MASK_ARM   = 5'b11000;

	localparam logic [CFG_ADDR_W-1:0] CFG_MANUAL_STEP  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_SLEW_STEP    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_MIN    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_MAX    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_TIMEOUT = 3'd4;

	localparam step_t             RST_MANUAL_STEP  = 5'd2;
	localparam step_t             RST_SLEW_STEP    = 5'd3;
	localparam angle_t            RST_ANGLE_MIN    = 8'd0;
	localparam angle_t            RST_ANGLE_MAX    = 8'd180;
	localparam logic [IDLE_W-1:0] RST_IDLE_TIMEOUT = 8'd40;
	localparam angle_t            RST_ANGLE        = 8'd90;

	// below the lower limit wins over above the upper one
	function automatic angle_t clamp_angle(input logic signed [CLAMP_W-1:0] v,
	                                       input angle_t lo, input angle_t hi);
		angle_t r;
		if (v < $signed({3'b000, lo})) begin
			r = lo;
		end else if (v > $signed({3'b000, hi})) begin
			r = hi;
		end else begin
			r = v[ANGLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/five_servo_jog_and_slew_controller.sv -----
// Five-servo jog and slew controller: input register, state update, result word.
// Depends on fsjsc_pkg for codes, widths, reset values and the clamp function.
//
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------------
// in       | in_valid / in_ready    | opcode, command_code, servo_index, target_angle
// out      | out_valid / out_ready  | angle_*, moving_mask, in_position_mode,
//          |                        | current_command
// cfg      | cfg_we                 | cfg_addr, cfg_wdata
//
// one word per cycle sustained while out_ready is high; each word is taken into the
// input register, then updates the servo state, which is also the result word.
// arst_n puts all servos at 90, targets at 90, manual mode, stop, config defaults.
// a result waiting on out_ready holds the input register; in_ready stays high
// whenever the input register is empty or moves forward in the same cycle.
module five_servo_jog_and_slew_controller
	import fsjsc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               opcode,
	input  logic [CMD_W-1:0]         command_code,
	input  logic [IDX_W-1:0]         servo_index,
	input  logic signed [TGT_W-1:0]  target_angle,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ANGLE_W-1:0]       angle_claw,
	output logic [ANGLE_W-1:0]       angle_wrist,
	output logic [ANGLE_W-1:0]       angle_tilt,
	output logic [ANGLE_W-1:0]       angle_arm_a,
	output logic [ANGLE_W-1:0]       angle_arm_b,
	output logic [NUM_SERVOS-1:0]    moving_mask,
	output logic                     in_position_mode,
	output logic [CMD_W-1:0]         current_command
);

	// configuration
	step_t             manual_step_q;
	step_t             slew_step_q;
	angle_t            angle_min_q;
	angle_t            angle_max_q;
	logic [IDLE_W-1:0] idle_timeout_q;

	// input register
	logic                     valid_s1;
	opcode_t                  op_s1;
	cmd_t                     code_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic signed [TGT_W-1:0]  tgt_s1;

	// servo state, which doubles as the result word
	angle_t            angle_q  [NUM_SERVOS];
	angle_t            target_q [NUM_SERVOS];
	servo_mask_t       moving_q;
	logic              mode_q;
	cmd_t              cmd_q;
	logic [IDLE_W-1:0] idle_q;
	logic              out_valid_q;

	angle_t            angle_n  [NUM_SERVOS];
	angle_t            target_n [NUM_SERVOS];
	servo_mask_t       moving_n;
	logic              mode_n;
	cmd_t              cmd_n;
	logic [IDLE_W-1:0] idle_n;
	logic [IDLE_W-1:0] idle_inc;

	logic              advance;
	servo_mask_t       jog_up;
	servo_mask_t       jog_dn;
	servo_mask_t       slew_busy;
	angle_t            man_angle  [NUM_SERVOS];
	angle_t            slew_angle [NUM_SERVOS];
	angle_t            tgt_clamped;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_step_q  <= RST_MANUAL_STEP;
			slew_step_q    <= RST_SLEW_STEP;
			angle_min_q    <= RST_ANGLE_MIN;
			angle_max_q    <= RST_ANGLE_MAX;
			idle_timeout_q <= RST_IDLE_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MANUAL_STEP:  manual_step_q  <= cfg_wdata[STEP_W-1:0];
				CFG_SLEW_STEP:    slew_step_q    <= cfg_wdata[STEP_W-1:0];
				CFG_ANGLE_MIN:    angle_min_q    <= cfg_wdata[ANGLE_W-1:0];
				CFG_ANGLE_MAX:    angle_max_q    <= cfg_wdata[ANGLE_W-1:0];
				CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_wdata[IDLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= opcode_t'(opcode);
			code_s1 <= command_code;
			idx_s1  <= servo_index;
			tgt_s1  <= target_angle;
		end
	end

	// which servos the active jog command drives, and in which direction
	always_comb begin
		jog_up = '0;
		jog_dn = '0;
		case (cmd_q)
			CMD_UP: begin
				jog_up[SERVO_ARM_A] = 1'b1;
				jog_dn[SERVO_ARM_B] = 1'b1;
			end
			CMD_DOWN: begin
				jog_dn[SERVO_ARM_A] = 1'b1;
				jog_up[SERVO_ARM_B] = 1'b1;
			end
			CMD_CLOSE:     jog_up[SERVO_CLAW]  = 1'b1;
			CMD_OPEN:      jog_dn[SERVO_CLAW]  = 1'b1;
			CMD_WRIST_CCW: jog_dn[SERVO_WRIST] = 1'b1;
			CMD_WRIST_CW:  jog_up[SERVO_WRIST] = 1'b1;
			CMD_TILT_UP:   jog_up[SERVO_TILT]  = 1'b1;
			CMD_TILT_DOWN: jog_dn[SERVO_TILT]  = 1'b1;
			default: ;
		endcase
	end

	// one add-and-clamp unit per servo
	for (genvar g = 0; g < NUM_SERVOS; g++) begin : g_servo
		logic [ANGLE_W:0]          up_sum;
		logic [ANGLE_W:0]          dn_lim;
		logic signed [CLAMP_W-1:0] man_up;
		logic signed [CLAMP_W-1:0] man_dn;

		assign up_sum = {1'b0, angle_q[g]} + {4'b0000, slew_step_q};
		assign dn_lim = {1'b0, target_q[g]} + {4'b0000, slew_step_q};
		assign man_up = $signed({3'b000, angle_q[g]}) + $signed({6'b000000, manual_step_q});
		assign man_dn = $signed({3'b000, angle_q[g]}) - $signed({6'b000000, manual_step_q});
		assign slew_busy[g] = angle_q[g] != target_q[g];
		assign man_angle[g] = jog_up[g] ? clamp_angle(man_up, angle_min_q, angle_max_q)
		                                : clamp_angle(man_dn, angle_min_q, angle_max_q);

		always_comb begin
			if (angle_q[g] < target_q[g]) begin
				slew_angle[g] = (up_sum > {1'b0, target_q[g]}) ? target_q[g]
				                                                : up_sum[ANGLE_W-1:0];
			end else if ({1'b0, angle_q[g]} >= dn_lim) begin
				slew_angle[g] = angle_q[g] - {3'b000, slew_step_q};
			end else begin
				slew_angle[g] = target_q[g];
			end
		end
	end

	assign tgt_clamped = clamp_angle({tgt_s1[TGT_W-1], tgt_s1}, angle_min_q, angle_max_q);
	assign idle_inc    = (idle_q == {IDLE_W{1'b1}}) ? idle_q : idle_q + 1'b1;

	always_comb begin
		angle_n  = angle_q;
		target_n = target_q;
		moving_n = moving_q;
		mode_n   = mode_q;
		cmd_n    = cmd_q;
		idle_n   = '0;
		case (op_s1)
			OP_TICK: begin
				if (mode_q) begin
					for (int i = 0; i < NUM_SERVOS; i++) begin
						if (moving_q[i]) begin
							if (slew_busy[i]) begin
								angle_n[i] = slew_angle[i];
							end else begin
								moving_n[i] = 1'b0;
							end
						end
					end
					if ((moving_q & slew_busy) == '0) begin
						mode_n = 1'b0;
					end
				end else begin
					for (int i = 0; i < NUM_SERVOS; i++) begin
						if (moving_q[i] && (jog_up[i] || jog_dn[i])) begin
							angle_n[i] = man_angle[i];
						end
					end
				end
				idle_n = idle_inc;
				// idle timeout stops an active command
				if (idle_inc >= idle_timeout_q && cmd_q != CMD_STOP) begin
					cmd_n    = CMD_STOP;
					moving_n = '0;
				end
			end
			OP_JOG: begin
				if (code_s1 <= CMD_WRIST_CW) begin
					cmd_n  = code_s1;
					mode_n = 1'b0;
					case (code_s1)
						CMD_STOP:                  moving_n = '0;
						CMD_UP, CMD_DOWN:          moving_n = moving_q | MASK_ARM;
						CMD_CLOSE, CMD_OPEN:       moving_n = moving_q | MASK_CLAW;
						CMD_WRIST_CCW, CMD_WRIST_CW: moving_n = moving_q | MASK_WRIST;
						default:                   moving_n = moving_q | MASK_TILT;
					endcase
				end
			end
			OP_SET_TARGET: begin
				mode_n = 1'b1;
				cmd_n  = CMD_STOP;
				for (int i = 0; i < NUM_SERVOS; i++) begin
					if (idx_s1 == IDX_W'(i)) begin
						target_n[i] = tgt_clamped;
						moving_n[i] = 1'b1;
					end
				end
			end
			OP_RAW: begin
				cmd_n  = (code_s1 > CMD_OTHER) ? CMD_OTHER : code_s1;
				mode_n = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SERVOS; i++) begin
				angle_q[i]  <= RST_ANGLE;
				target_q[i] <= RST_ANGLE;
			end
			moving_q    <= '0;
			mode_q      <= 1'b0;
			cmd_q       <= CMD_STOP;
			idle_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				angle_q     <= angle_n;
				target_q    <= target_n;
				moving_q    <= moving_n;
				mode_q      <= mode_n;
				cmd_q       <= cmd_n;
				idle_q      <= idle_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign angle_claw       = angle_q[SERVO_CLAW];
	assign angle_wrist      = angle_q[SERVO_WRIST];
	assign angle_tilt       = angle_q[SERVO_TILT];
	assign angle_arm_a      = angle_q[SERVO_ARM_A];
	assign angle_arm_b      = angle_q[SERVO_ARM_B];
	assign moving_mask      = moving_q;
	assign in_position_mode = mode_q;
	assign current_command  = cmd_q;

`ifndef NO_ASSERTIONS
	// the input side never stalls behind an empty result slot
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("in_ready low with empty result slot");

	// stored command is always a legal code
	a_cmd_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q <= CMD_OTHER)
		else $error("illegal command code stored");

	// a set-target word enters position mode with the command stopped
	a_set_target: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_SET_TARGET |=> mode_q && cmd_q == CMD_STOP)
		else $error("set target did not enter position mode");

	// a position tick with nothing moving falls back to manual
	a_drop_manual: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_TICK && mode_q && moving_q == '0 |=> !mode_q)
		else $error("position mode kept with no servo moving");
`endif

endmodule

// ----- verif/fsjsc_scoreboard_pkg.sv -----
// Scoreboard for the five-servo jog and slew controller: state predictor and result checks.
// Depends on fsjsc_pkg for widths, opcodes, command codes, masks and reset values.
package fsjsc_scoreboard_pkg;
	import fsjsc_pkg::*;

	typedef struct packed {
		logic [NUM_SERVOS-1:0][ANGLE_W-1:0] angles;
		servo_mask_t                        moving;
		logic                               pos_mode;
		cmd_t                               cmd;
	} servo_word_t;

	class servo_scoreboard;
		// predicted servo state
		int          pos[NUM_SERVOS];
		int          goal[NUM_SERVOS];
		servo_mask_t moving;
		bit          slewing;
		cmd_t        cmd;
		int          idle_ticks;
		// register copies
		int          jog_step;
		int          slew_rate;
		int          lim_lo;
		int          lim_hi;
		int          idle_limit;

		servo_word_t expected_words[$];
		int          errors;

		function new();
			for (int i = 0; i < NUM_SERVOS; i++) begin
				pos[i]  = RST_ANGLE;
				goal[i] = RST_ANGLE;
			end
			moving     = '0;
			slewing    = 1'b0;
			cmd        = CMD_STOP;
			idle_ticks = 0;
			jog_step   = RST_MANUAL_STEP;
			slew_rate  = RST_SLEW_STEP;
			lim_lo     = RST_ANGLE_MIN;
			lim_hi     = RST_ANGLE_MAX;
			idle_limit = RST_IDLE_TIMEOUT;
			errors     = 0;
		endfunction

		function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
			case (addr)
				CFG_MANUAL_STEP:  jog_step   = data[STEP_W-1:0];
				CFG_SLEW_STEP:    slew_rate  = data[STEP_W-1:0];
				CFG_ANGLE_MIN:    lim_lo     = data;
				CFG_ANGLE_MAX:    lim_hi     = data;
				CFG_IDLE_TIMEOUT: idle_limit = data;
				default: ;
			endcase
		endfunction

		// low limit is checked first, so it wins when the limits cross
		function int limit(int v);
			if (v < lim_lo) return lim_lo;
			if (v > lim_hi) return lim_hi;
			return v;
		endfunction

		function void nudge(int i, int dir);
			if (moving[i])
				pos[i] = limit(pos[i] + dir * jog_step) & 8'hff;
		endfunction

		function void manual_tick();
			case (cmd)
				CMD_WRIST_CCW: nudge(SERVO_WRIST, -1);
				CMD_WRIST_CW:  nudge(SERVO_WRIST, 1);
				CMD_TILT_UP:   nudge(SERVO_TILT, 1);
				CMD_TILT_DOWN: nudge(SERVO_TILT, -1);
				CMD_UP: begin
					nudge(SERVO_ARM_A, 1);
					nudge(SERVO_ARM_B, -1);
				end
				CMD_DOWN: begin
					nudge(SERVO_ARM_A, -1);
					nudge(SERVO_ARM_B, 1);
				end
				CMD_CLOSE: nudge(SERVO_CLAW, 1);
				CMD_OPEN:  nudge(SERVO_CLAW, -1);
				default: ;
			endcase
		endfunction

		function void slew_tick();
			bit any;
			int a;
			int t;
			any = 1'b0;
			for (int i = 0; i < NUM_SERVOS; i++) begin
				if (moving[i]) begin
					a = pos[i];
					t = goal[i];
					if (a < t) begin
						a = a + slew_rate;
						pos[i] = (a > t) ? t : a;
						any = 1'b1;
					end else if (a > t) begin
						pos[i] = (a >= t + slew_rate) ? a - slew_rate : t;
						any = 1'b1;
					end else begin
						moving[i] = 1'b0;
					end
				end
			end
			if (!any)
				slewing = 1'b0;
		endfunction

		// accepted input word: update the state and queue the word it must produce
		function void take_word(opcode_t op, cmd_t code, logic [IDX_W-1:0] idx, int tgt);
			servo_word_t w;
			if (op == OP_TICK) begin
				if (slewing)
					slew_tick();
				else
					manual_tick();
				if (idle_ticks < 255)
					idle_ticks++;
				if (idle_ticks >= idle_limit && cmd != CMD_STOP) begin
					cmd    = CMD_STOP;
					moving = '0;
				end
			end else begin
				idle_ticks = 0;
				case (op)
					OP_JOG: begin
						// codes past wrist cw are ignored
						if (code <= CMD_WRIST_CW) begin
							cmd     = code;
							slewing = 1'b0;
							case (code)
								CMD_STOP:                moving = '0;
								CMD_UP, CMD_DOWN:        moving |= MASK_ARM;
								CMD_CLOSE, CMD_OPEN:     moving |= MASK_CLAW;
								CMD_WRIST_CCW, CMD_WRIST_CW: moving |= MASK_WRIST;
								default:                 moving |= MASK_TILT;
							endcase
						end
					end
					OP_SET_TARGET: begin
						slewing = 1'b1;
						cmd     = CMD_STOP;
						if (idx < NUM_SERVOS) begin
							goal[idx]   = limit(tgt) & 8'hff;
							moving[idx] = 1'b1;
						end
					end
					default: begin
						cmd     = (code > CMD_OTHER) ? CMD_OTHER : code;
						slewing = 1'b0;
					end
				endcase
			end
			for (int i = 0; i < NUM_SERVOS; i++)
				w.angles[i] = ANGLE_W'(pos[i]);
			w.moving   = moving;
			w.pos_mode = slewing;
			w.cmd      = cmd;
			expected_words.push_back(w);
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void check_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				if (errors <= 10)
					$display("%s: expected %0d, got %0d", name, want, got);
			end
		endfunction

		function void check_word(servo_word_t got);
			servo_word_t want;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result word with nothing expected");
				return;
			end
			want = expected_words.pop_front();
			for (int i = 0; i < NUM_SERVOS; i++)
				check_field($sformatf("angle of servo %0d", i), want.angles[i], got.angles[i]);
			check_field("moving_mask", want.moving, got.moving);
			check_field("in_position_mode", want.pos_mode, got.pos_mode);
			check_field("current_command", want.cmd, got.cmd);
		endfunction
	endclass

endpackage

// ----- verif/tb_top.sv -----
// Testbench top for the five-servo jog and slew controller: stimulus, idling and checks.
// Depends on fsjsc_pkg and fsjsc_scoreboard_pkg; drives the dut through its ports only.
module tb_top;
	import fsjsc_pkg::*;
	import fsjsc_scoreboard_pkg::*;

	localparam int PHASE_WORDS  = 180;
	localparam int LONG_HOLD    = 60;
	localparam int LIMIT_CYCLES = 1000000;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_ADDR_W-1:0]   cfg_addr;
	logic [CFG_DATA_W-1:0]   cfg_wdata;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              opcode;
	logic [CMD_W-1:0]        command_code;
	logic [IDX_W-1:0]        servo_index;
	logic signed [TGT_W-1:0] target_angle;
	logic                    out_valid;
	logic                    out_ready;
	logic [ANGLE_W-1:0]      angle_claw;
	logic [ANGLE_W-1:0]      angle_wrist;
	logic [ANGLE_W-1:0]      angle_tilt;
	logic [ANGLE_W-1:0]      angle_arm_a;
	logic [ANGLE_W-1:0]      angle_arm_b;
	logic [NUM_SERVOS-1:0]   moving_mask;
	logic                    in_position_mode;
	logic [CMD_W-1:0]        current_command;

	servo_scoreboard sb;
	int              words_sent = 0;
	int              holds_asked = 0;
	int              holds_done = 0;

	five_servo_jog_and_slew_controller dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.command_code     (command_code),
		.servo_index      (servo_index),
		.target_angle     (target_angle),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.angle_claw       (angle_claw),
		.angle_wrist      (angle_wrist),
		.angle_tilt       (angle_tilt),
		.angle_arm_a      (angle_arm_a),
		.angle_arm_b      (angle_arm_b),
		.moving_mask      (moving_mask),
		.in_position_mode (in_position_mode),
		.current_command  (current_command)
	);

	always #5 clk = ~clk;

	// mostly back to back or short, now and then a long gap
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic cmd_t any_code();
		return cmd_t'($urandom_range(0, 15));
	endfunction

	function automatic logic [IDX_W-1:0] any_idx();
		return IDX_W'($urandom_range(0, 7));
	endfunction

	function automatic logic signed [TGT_W-1:0] any_tgt();
		return TGT_W'($urandom_range(0, 1023));
	endfunction

	always @(posedge clk) begin : monitor
		servo_word_t got;
		if (arst_n) begin
			if (cfg_we)
				sb.set_reg(cfg_addr, cfg_wdata);
			if (in_valid && in_ready)
				sb.take_word(opcode_t'(opcode), command_code, servo_index, int'(target_angle));
			if (out_valid && out_ready) begin
				got.angles   = {angle_arm_b, angle_arm_a, angle_tilt, angle_wrist, angle_claw};
				got.moving   = moving_mask;
				got.pos_mode = in_position_mode;
				got.cmd      = current_command;
				sb.check_word(got);
			end
		end
	end

	// result side: random stalls plus a long hold whenever the stimulus asks for one
	initial begin : receiver
		int burst;
		int gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 30);
			out_ready <= 1'b1;
			repeat (burst) @(posedge clk);
			if (holds_asked != holds_done) begin
				holds_done++;
				gap = LONG_HOLD;
			end else begin
				gap = idle_len();
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	task automatic send_word(opcode_t op, cmd_t code, logic [IDX_W-1:0] idx,
	                         logic signed [TGT_W-1:0] tgt, bit eager);
		int gap;
		gap = eager ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		command_code <= code;
		servo_index  <= idx;
		target_angle <= tgt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_tick(bit eager);
		send_word(OP_TICK, any_code(), any_idx(), any_tgt(), eager);
	endtask

	// wait for every expected word with the input idle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(logic [CFG_ADDR_W-1:0] addr, int data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= CFG_DATA_W'(data);
		@(posedge clk);
	endtask

	task automatic apply_settings(int m_step, int s_step, int lo, int hi, int timeout);
		put_reg(CFG_MANUAL_STEP, m_step);
		put_reg(CFG_SLEW_STEP, s_step);
		put_reg(CFG_ANGLE_MIN, lo);
		put_reg(CFG_ANGLE_MAX, hi);
		put_reg(CFG_IDLE_TIMEOUT, timeout);
		cfg_we <= 1'b0;
	endtask

	task automatic directed_words();
		send_tick(1'b0);
		send_word(OP_JOG, CMD_UP, 0, 0, 1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_word(OP_JOG, CMD_DOWN, 0, 0, 1'b1);
		send_tick(1'b0);
		send_word(OP_JOG, CMD_CLOSE, 0, 0, 1'b0);
		send_tick(1'b0);
		send_word(OP_JOG, CMD_OPEN, 0, 0, 1'b0);
		send_tick(1'b1);
		send_word(OP_JOG, CMD_WRIST_CCW, 0, 0, 1'b0);
		send_word(OP_JOG, CMD_WRIST_CW, 0, 0, 1'b0);
		send_tick(1'b0);
		send_word(OP_JOG, CMD_TILT_UP, 0, 0, 1'b0);
		send_word(OP_JOG, CMD_TILT_DOWN, 0, 0, 1'b1);
		send_tick(1'b0);
		// unknown jog codes are dropped, raw codes past other saturate
		send_word(OP_JOG, CMD_OTHER, 0, 0, 1'b0);
		send_word(OP_JOG, 4'd15, 0, 0, 1'b0);
		send_word(OP_RAW, 4'd12, 0, 0, 1'b0);
		send_tick(1'b0);
		send_word(OP_JOG, CMD_STOP, 0, 0, 1'b0);
		send_word(OP_SET_TARGET, CMD_STOP, IDX_W'(SERVO_CLAW), TGT_W'(-512), 1'b0);
		send_word(OP_SET_TARGET, CMD_STOP, IDX_W'(SERVO_ARM_B), TGT_W'(511), 1'b1);
		send_word(OP_SET_TARGET, CMD_STOP, 3'd7, TGT_W'(5), 1'b0);
		send_tick(1'b0);
		send_word(OP_RAW, CMD_STOP, 0, 0, 1'b0);
	endtask

	// mostly jog and slew sequences with random content, some noise in between
	task automatic random_words(int n);
		int start;
		int pick;
		int reps;
		bit eager;
		logic [IDX_W-1:0]        idx;
		logic signed [TGT_W-1:0] tgt;
		start = words_sent;
		while (words_sent - start < n) begin
			pick  = $urandom_range(0, 99);
			eager = ($urandom_range(0, 9) == 0);
			if (pick < 35) begin
				if ($urandom_range(0, 9) == 0)
					send_word(OP_JOG, cmd_t'($urandom_range(9, 15)), any_idx(), any_tgt(), eager);
				else
					send_word(OP_JOG, cmd_t'($urandom_range(0, 8)), any_idx(), any_tgt(), eager);
				reps = $urandom_range(1, 12);
				repeat (reps) send_tick(eager);
			end else if (pick < 65) begin
				reps = $urandom_range(1, 5);
				repeat (reps) begin
					idx = IDX_W'(($urandom_range(0, 11) == 0) ? $urandom_range(5, 7)
					                                          : $urandom_range(0, 4));
					tgt = ($urandom_range(0, 3) == 0) ? any_tgt() : TGT_W'($urandom_range(0, 255));
					send_word(OP_SET_TARGET, any_code(), idx, tgt, eager);
				end
				reps = $urandom_range(1, 40);
				repeat (reps) send_tick(eager);
			end else if (pick < 75) begin
				send_word(OP_RAW, any_code(), any_idx(), any_tgt(), eager);
				reps = $urandom_range(0, 4);
				repeat (reps) send_tick(eager);
			end else if (pick < 85) begin
				// run into the idle timeout with a command active, for idle limits up to 70
				send_word(OP_JOG, cmd_t'($urandom_range(1, 8)), any_idx(), any_tgt(), eager);
				reps = (sb.idle_limit < 69) ? sb.idle_limit + 1 : 70;
				repeat (reps) send_tick(eager);
			end else begin
				reps = $urandom_range(1, 3);
				repeat (reps)
					send_word(opcode_t'($urandom_range(0, 3)), any_code(), any_idx(), any_tgt(),
					          eager);
			end
		end
	endtask

	// long output hold while words keep coming, so the input side backs up
	task automatic press_input();
		holds_asked++;
		repeat (80) begin
			if ($urandom_range(0, 1) == 0)
				send_tick(1'b1);
			else
				send_word(opcode_t'($urandom_range(0, 3)), any_code(), any_idx(), any_tgt(), 1'b1);
		end
	endtask

	initial begin : stimulus
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_addr     = CFG_MANUAL_STEP;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		opcode       = OP_TICK;
		command_code = CMD_STOP;
		servo_index  = '0;
		target_angle = '0;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_words();
		random_words(PHASE_WORDS);
		settle();

		apply_settings(31, 31, 0, 255, 255);
		press_input();
		random_words(PHASE_WORDS);
		settle();

		apply_settings(1, 1, 0, 0, 1);
		random_words(PHASE_WORDS);
		settle();

		// crossed limits and a zero timeout
		apply_settings(7, 5, 200, 50, 0);
		random_words(PHASE_WORDS);
		settle();

		apply_settings(1, 31, 255, 255, 3);
		random_words(PHASE_WORDS);
		settle();

		repeat (3) begin
			apply_settings($urandom_range(1, 31), $urandom_range(1, 31), $urandom_range(0, 120),
			               $urandom_range(100, 255), $urandom_range(1, 60));
			press_input();
			random_words(PHASE_WORDS);
			settle();
		end

		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("five_servo_jog_and_slew_controller: match");
		else
			$display("five_servo_jog_and_slew_controller: mismatch");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_CYCLES * 10);
		$display("five_servo_jog_and_slew_controller: mismatch");
		$finish;
	end

endmodule
